FILE: rtl/core/hcpc_pkg.sv
// Shared types and constants for the Hall commutation position counter.
// Used by hcpc_decode and hall_commutation_position_counter; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hcpc_pkg;

   // Item commands.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   // Register indexes on the configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALL_TABLE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_ENABLE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORWARD_ORDER = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_INVERT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET        = 3'd4;

   // Field widths.
   localparam int unsigned CODE_W      = 3;
   localparam int unsigned TABLE_W     = 18;
   localparam int unsigned POS_W       = 32;
   localparam int unsigned TIMER_W     = 16;
   localparam int unsigned OVF_W       = 5;
   localparam int unsigned PAIR_W      = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned TABLE_DEPTH = 6;

   // Reset values and limits.
   localparam logic [TABLE_W-1:0] TABLE_RESET    = 18'd183449;
   localparam logic [OVF_W-1:0]   OVERFLOW_LIMIT = 5'd20;
   localparam logic [PAIR_W-1:0]  NO_PAIR        = 3'd6;

   // Table lookup result for one Hall sample.
   typedef struct packed {
      logic              step_fwd;
      logic              step_back;
      logic [PAIR_W-1:0] pair;
   } step_info_type;

   // One result beat.
   typedef struct packed {
      logic [PAIR_W-1:0]  drive_pair;
      logic [POS_W-1:0]   position;
      logic               target_hit;
      logic               hall_fault;
      logic               restart_timer;
      logic [OVF_W-1:0]   period_overflows;
      logic [TIMER_W-1:0] period_fraction;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/hcpc_decode.sv
// Hall rotation table lookup: step direction from old to new code, and phase pair.
// Depends on hcpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hcpc_decode (
   input  wire logic [hcpc_pkg::TABLE_W-1:0] hall_table,
   input  wire logic [hcpc_pkg::CODE_W-1:0]  prev_code,
   input  wire logic [hcpc_pkg::CODE_W-1:0]  new_code,
   input  wire logic                         forward_order,
   output hcpc_pkg::step_info_type           info
);

   logic [hcpc_pkg::CODE_W-1:0] entry   [hcpc_pkg::TABLE_DEPTH];
   logic [hcpc_pkg::CODE_W-1:0] ordered [hcpc_pkg::TABLE_DEPTH];

   // Split the table and build the pair order (shifted order starts at entry three).
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         entry[i] = hall_table[i*3 +: 3];
      end
      for (int n = 0; n < 6; n++) begin
         ordered[n] = forward_order ? entry[n] : ((n < 3) ? entry[n+3] : entry[n-3]);
      end
   end

   // The first entry holding the old code decides; scanning downward lets the
   // lowest match overwrite the others. A forward match wins over a backward one.
   always_comb begin
      info = '{step_fwd: 1'b0, step_back: 1'b0, pair: hcpc_pkg::NO_PAIR};
      for (int i = 5; i >= 0; i--) begin
         if (entry[i] == prev_code) begin
            info.step_fwd  = (new_code == entry[(i == 5) ? 0 : i + 1]);
            info.step_back = (new_code != entry[(i == 5) ? 0 : i + 1])
                             && (new_code == entry[(i == 0) ? 5 : i - 1]);
         end
      end
      for (int n = 5; n >= 0; n--) begin
         if (ordered[n] == new_code) begin
            info.pair = 3'(5 - n);
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/hall_commutation_position_counter.sv
// Hall commutation position counter: step counting, fault, period capture, pair select.
// Depends on hcpc_pkg and hcpc_decode.
//
// Usage:
//   Input beats (req_*) carry either a Hall sample (req_command = 0, with
//   req_hall_code and req_timer_value) or a period timer overflow tick
//   (req_command = 1). Every input beat yields exactly one result beat on rsp_*.
//   Registers are written through csr_valid/csr_ready with csr_index and
//   csr_data; csr_ready is always high, and writes belong in idle periods.
//   Throughput: one item per cycle while req_stall is low; the whole lookup,
//   the position add and the target compare sit between the input ports and
//   the result register, or the skid register behind a stalled result.
//   Stall: a stalled result holds on rsp_*. One more item is still taken into
//   a skid register; then req_stall rises until the result register drains.
//   Reset: all counters, flags and the stored Hall code clear, registers
//   return to their reset values, and pending results are dropped. The
//   first sample after reset only records its code.
`timescale 1ns / 1ps
`default_nettype none

module hall_commutation_position_counter (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Input channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_command,
   input  wire logic [hcpc_pkg::CODE_W-1:0]           req_hall_code,
   input  wire logic [hcpc_pkg::TIMER_W-1:0]          req_timer_value,
   // Result channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [hcpc_pkg::PAIR_W-1:0]                rsp_drive_pair,
   output logic signed [hcpc_pkg::POS_W-1:0]          rsp_position,
   output logic                                       rsp_target_hit,
   output logic                                       rsp_hall_fault,
   output logic                                       rsp_restart_timer,
   output logic [hcpc_pkg::OVF_W-1:0]                 rsp_period_overflows,
   output logic [hcpc_pkg::TIMER_W-1:0]               rsp_period_fraction,
   // Configuration port
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [hcpc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [hcpc_pkg::CSR_DATA_W-1:0]       csr_data
);

   // Configuration registers
   logic [hcpc_pkg::TABLE_W-1:0] hall_table_ff;
   logic                         drive_enable_ff;
   logic                         forward_order_ff;
   logic                         count_invert_ff;
   logic [hcpc_pkg::POS_W-1:0]   target_ff;

   // Block state
   logic [hcpc_pkg::CODE_W-1:0]  prev_code_ff,   prev_code_in;
   logic                         prev_valid_ff,  prev_valid_in;
   logic                         armed_ff,       armed_in;
   logic [hcpc_pkg::OVF_W-1:0]   ovf_count_ff,   ovf_count_in;
   logic [hcpc_pkg::OVF_W-1:0]   cap_ovf_ff,     cap_ovf_in;
   logic [hcpc_pkg::TIMER_W-1:0] cap_frac_ff,    cap_frac_in;
   logic [hcpc_pkg::POS_W-1:0]   position_ff,    position_in;
   logic                         fault_ff,       fault_in;

   // Output register and skid stage
   hcpc_pkg::rsp_type            out_ff,         out_in;
   logic                         out_valid_ff,   out_valid_in;
   hcpc_pkg::rsp_type            skid_ff,        skid_in;
   logic                         skid_valid_ff,  skid_valid_in;

   hcpc_pkg::step_info_type      info;
   hcpc_pkg::rsp_type            result;
   logic                         accept;
   logic                         out_free;
   logic                         step;
   logic                         step_up;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         hall_table_ff    <= hcpc_pkg::TABLE_RESET;
         drive_enable_ff  <= 1'b0;
         forward_order_ff <= 1'b1;
         count_invert_ff  <= 1'b0;
         target_ff        <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hcpc_pkg::CSR_HALL_TABLE:    hall_table_ff    <= csr_data[hcpc_pkg::TABLE_W-1:0];
            hcpc_pkg::CSR_DRIVE_ENABLE:  drive_enable_ff  <= csr_data[0];
            hcpc_pkg::CSR_FORWARD_ORDER: forward_order_ff <= csr_data[0];
            hcpc_pkg::CSR_COUNT_INVERT:  count_invert_ff  <= csr_data[0];
            hcpc_pkg::CSR_TARGET:        target_ff        <= csr_data[hcpc_pkg::POS_W-1:0];
            default: ;
         endcase
      end
   end

   hcpc_decode u_decode (
      .hall_table    (hall_table_ff),
      .prev_code     (prev_code_ff),
      .new_code      (req_hall_code),
      .forward_order (forward_order_ff),
      .info          (info)
   );

   // Per-item state update and result.
   always_comb begin
      prev_code_in  = prev_code_ff;
      prev_valid_in = prev_valid_ff;
      armed_in      = armed_ff;
      ovf_count_in  = ovf_count_ff;
      cap_ovf_in    = cap_ovf_ff;
      cap_frac_in   = cap_frac_ff;
      position_in   = position_ff;
      fault_in      = fault_ff;
      step          = 1'b0;
      step_up       = 1'b0;
      result.drive_pair    = hcpc_pkg::NO_PAIR;
      result.target_hit    = 1'b0;
      result.restart_timer = 1'b0;

      if (req_command == hcpc_pkg::CMD_TICK) begin
         // Overflow tick: saturating count, captured count follows it.
         if (ovf_count_ff < hcpc_pkg::OVERFLOW_LIMIT) begin
            ovf_count_in = ovf_count_ff + 1'b1;
         end
         cap_ovf_in  = ovf_count_in;
         cap_frac_in = '0;
      end else begin
         // Hall sample: count one step forward or back, otherwise fault once a previous code is held.
         step    = prev_valid_ff && (info.step_fwd || info.step_back);
         step_up = info.step_fwd ^ count_invert_ff;
         if (prev_valid_ff && !step) begin
            fault_in = 1'b1;
         end
         if (step) begin
            if (!armed_ff) begin
               armed_in     = 1'b1;
               ovf_count_in = '0;
               result.restart_timer = 1'b1;
            end else begin
               armed_in    = 1'b0;
               cap_frac_in = req_timer_value;
               cap_ovf_in  = ovf_count_ff;
            end
            position_in = step_up ? position_ff + 1'b1 : position_ff - 1'b1;
            result.target_hit = (position_in == target_ff);
         end
         prev_code_in  = req_hall_code;
         prev_valid_in = 1'b1;
         if (drive_enable_ff) begin
            result.drive_pair = info.pair;
         end
      end

      result.position         = position_in;
      result.hall_fault       = fault_in;
      result.period_overflows = cap_ovf_in;
      result.period_fraction  = cap_frac_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_code_ff  <= '0;
         prev_valid_ff <= 1'b0;
         armed_ff      <= 1'b0;
         ovf_count_ff  <= '0;
         cap_ovf_ff    <= '0;
         cap_frac_ff   <= '0;
         position_ff   <= '0;
         fault_ff      <= 1'b0;
      end else if (accept) begin
         prev_code_ff  <= prev_code_in;
         prev_valid_ff <= prev_valid_in;
         armed_ff      <= armed_in;
         ovf_count_ff  <= ovf_count_in;
         cap_ovf_ff    <= cap_ovf_in;
         cap_frac_ff   <= cap_frac_in;
         position_ff   <= position_in;
         fault_ff      <= fault_in;
      end
   end

   // Output register with one skid entry behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_drive_pair       = out_ff.drive_pair;
   assign rsp_position         = out_ff.position;
   assign rsp_target_hit       = out_ff.target_hit;
   assign rsp_hall_fault       = out_ff.hall_fault;
   assign rsp_restart_timer    = out_ff.restart_timer;
   assign rsp_period_overflows = out_ff.period_overflows;
   assign rsp_period_fraction  = out_ff.period_fraction;

`ifndef SYNTHESIS
   // The skid entry only fills behind a held result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without a result in the output register");

   // The fault flag is sticky until reset.
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_ff |=> fault_ff)
      else $error("fault flag cleared without reset");

   // The overflow count saturates at its limit.
   a_ovf_limit: assert property (@(posedge clock) disable iff (reset)
      ovf_count_ff <= hcpc_pkg::OVERFLOW_LIMIT)
      else $error("overflow count beyond its limit");

   // A timer tick never changes the period phase or the position.
   a_tick_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == hcpc_pkg::CMD_TICK)
      |=> ($stable(armed_ff) && $stable(position_ff)))
      else $error("timer tick changed period phase or position");

   // A restart request comes only with a counted step that arms the capture.
   a_restart_arms: assert property (@(posedge clock) disable iff (reset)
      (accept && result.restart_timer) |=> armed_ff)
      else $error("restart issued without arming the capture");
`endif

endmodule

`default_nettype wire

FILE: tb/hall_commutation_position_counter_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the Hall commutation position counter: directed and random
// Hall samples and timer ticks, checked beat by beat against an in-bench predictor.
// Depends on hcpc_pkg and the hall_commutation_position_counter RTL.

module hall_commutation_position_counter_test;
   import hcpc_pkg::*;

   // Predicts each result beat from the accepted input beats and checks the block's output.
   class hall_position_scoreboard;
      logic [TABLE_W-1:0] hall_table;
      logic               drive_enable;
      logic               forward_order;
      logic               count_invert;
      logic [POS_W-1:0]   target_position;

      logic [CODE_W-1:0]  last_code;
      logic               code_seen;
      logic               armed;
      logic [OVF_W-1:0]   overflow_run;
      logic [OVF_W-1:0]   held_overflows;
      logic [TIMER_W-1:0] held_fraction;
      logic [POS_W-1:0]   step_count;
      logic               fault_seen;

      rsp_type expected_readings[$];
      int      mismatch_count;

      function new();
         hall_table      = TABLE_RESET;
         drive_enable    = 1'b0;
         forward_order   = 1'b1;
         count_invert    = 1'b0;
         target_position = '0;
         last_code       = '0;
         code_seen       = 1'b0;
         armed           = 1'b0;
         overflow_run    = '0;
         held_overflows  = '0;
         held_fraction   = '0;
         step_count      = '0;
         fault_seen      = 1'b0;
         mismatch_count  = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_HALL_TABLE:    hall_table      = value[TABLE_W-1:0];
            CSR_DRIVE_ENABLE:  drive_enable    = value[0];
            CSR_FORWARD_ORDER: forward_order   = value[0];
            CSR_COUNT_INVERT:  count_invert    = value[0];
            CSR_TARGET:        target_position = value[POS_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CODE_W-1:0] entry_at(int slot);
         return hall_table[CODE_W*(slot % TABLE_DEPTH) +: CODE_W];
      endfunction

      // First table slot holding the code, or TABLE_DEPTH when it is missing.
      function int slot_of(logic [CODE_W-1:0] code);
         for (int k = 0; k < TABLE_DEPTH; k++)
            if (entry_at(k) == code)
               return k;
         return TABLE_DEPTH;
      endfunction

      // Forward order walks slots 0..5 onto pairs 5..0; the shifted order starts at slot 3.
      function logic [PAIR_W-1:0] pair_of(logic [CODE_W-1:0] code);
         int first;
         first = forward_order ? 0 : 3;
         for (int k = 0; k < TABLE_DEPTH; k++)
            if (entry_at(first + k) == code)
               return PAIR_W'(5 - k);
         return NO_PAIR;
      endfunction

      function void note_beat(logic cmd, logic [CODE_W-1:0] code, logic [TIMER_W-1:0] timer);
         rsp_type want;
         int      slot;
         int      dir;
         want.drive_pair    = NO_PAIR;
         want.target_hit    = 1'b0;
         want.restart_timer = 1'b0;
         if (cmd == CMD_TICK) begin
            // Overflow ticks count up to the limit and publish the running count.
            if (overflow_run < OVERFLOW_LIMIT)
               overflow_run = overflow_run + 1'b1;
            held_overflows = overflow_run;
            held_fraction  = '0;
         end else begin
            if (code_seen) begin
               slot = slot_of(last_code);
               dir  = 0;
               if (slot < TABLE_DEPTH) begin
                  if (code == entry_at(slot + 1))
                     dir = 1;
                  else if (code == entry_at(slot + 5))
                     dir = -1;
               end
               if (dir != 0) begin
                  // Valid steps alternately open and close a period measurement.
                  if (!armed) begin
                     armed              = 1'b1;
                     overflow_run       = '0;
                     want.restart_timer = 1'b1;
                  end else begin
                     armed          = 1'b0;
                     held_fraction  = timer;
                     held_overflows = overflow_run;
                  end
                  if (count_invert)
                     dir = -dir;
                  step_count = (dir > 0) ? step_count + 1'b1 : step_count - 1'b1;
                  want.target_hit = (step_count == target_position);
               end else begin
                  fault_seen = 1'b1;
               end
            end
            last_code = code;
            code_seen = 1'b1;
            if (drive_enable)
               want.drive_pair = pair_of(code);
         end
         want.position         = step_count;
         want.hall_fault       = fault_seen;
         want.period_overflows = held_overflows;
         want.period_fraction  = held_fraction;
         expected_readings.push_back(want);
      endfunction

      task report_mismatch(string what, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
         mismatch_count++;
         if (mismatch_count <= 200)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      endtask

      task check_beat(rsp_type got);
         rsp_type want;
         if (expected_readings.size() == 0) begin
            report_mismatch("unexpected result beat", got.position, '0);
            return;
         end
         want = expected_readings.pop_front();
         if (got.drive_pair !== want.drive_pair)
            report_mismatch("drive_pair", POS_W'(got.drive_pair), POS_W'(want.drive_pair));
         if (got.position !== want.position)
            report_mismatch("position", got.position, want.position);
         if (got.target_hit !== want.target_hit)
            report_mismatch("target_hit", POS_W'(got.target_hit), POS_W'(want.target_hit));
         if (got.hall_fault !== want.hall_fault)
            report_mismatch("hall_fault", POS_W'(got.hall_fault), POS_W'(want.hall_fault));
         if (got.restart_timer !== want.restart_timer)
            report_mismatch("restart_timer", POS_W'(got.restart_timer),
                            POS_W'(want.restart_timer));
         if (got.period_overflows !== want.period_overflows)
            report_mismatch("period_overflows", POS_W'(got.period_overflows),
                            POS_W'(want.period_overflows));
         if (got.period_fraction !== want.period_fraction)
            report_mismatch("period_fraction", POS_W'(got.period_fraction),
                            POS_W'(want.period_fraction));
      endtask

      function int waiting();
         return expected_readings.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   logic                   req_valid;
   logic                   req_stall;
   logic                   req_command;
   logic [CODE_W-1:0]      req_hall_code;
   logic [TIMER_W-1:0]     req_timer_value;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PAIR_W-1:0]      rsp_drive_pair;
   logic signed [POS_W-1:0] rsp_position;
   logic                   rsp_target_hit;
   logic                   rsp_hall_fault;
   logic                   rsp_restart_timer;
   logic [OVF_W-1:0]       rsp_period_overflows;
   logic [TIMER_W-1:0]     rsp_period_fraction;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   hall_position_scoreboard ledger = new();

   // Idle rates in percent and the long receiver hold-off, counted down by the receiver.
   int req_gap_pct   = 37;
   int rsp_stall_pct = 50;
   int hold_off_left = 0;

   // Random walk state over the table currently loaded in the block.
   logic [TABLE_W-1:0] table_now = TABLE_RESET;
   int walk_at  = 0;
   int walk_dir = 1;
   int tick_run = 0;

   hall_commutation_position_counter i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_hall_code        (req_hall_code),
      .req_timer_value      (req_timer_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_drive_pair       (rsp_drive_pair),
      .rsp_position         (rsp_position),
      .rsp_target_hit       (rsp_target_hit),
      .rsp_hall_fault       (rsp_hall_fault),
      .rsp_restart_timer    (rsp_restart_timer),
      .rsp_period_overflows (rsp_period_overflows),
      .rsp_period_fraction  (rsp_period_fraction),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #10 clock = ~clock;

   // Watch both channels; a result is checked before the same edge's input beat is noted.
   always @(posedge clock) begin
      rsp_type seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen.drive_pair       = rsp_drive_pair;
            seen.position         = rsp_position;
            seen.target_hit       = rsp_target_hit;
            seen.hall_fault       = rsp_hall_fault;
            seen.restart_timer    = rsp_restart_timer;
            seen.period_overflows = rsp_period_overflows;
            seen.period_fraction  = rsp_period_fraction;
            ledger.check_beat(seen);
         end
         if (req_valid && !req_stall)
            ledger.note_beat(req_command, req_hall_code, req_timer_value);
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            rsp_stall <= 1'b1;
            hold_off_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // Offer one beat after a random gap and wait until it is taken.
   task automatic send_beat(input logic cmd, input logic [CODE_W-1:0] code,
                            input logic [TIMER_W-1:0] timer);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_hall_code   <= code;
      req_timer_value <= timer;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering beats and wait until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.waiting() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      ledger.write_register(idx, value);
      if (idx == CSR_HALL_TABLE)
         table_now = value[TABLE_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Six distinct codes in random order, from 1..6 or from the whole 0..7 range.
   function automatic logic [TABLE_W-1:0] shuffled_table(input bit any_code);
      logic [CODE_W-1:0]  pool [8];
      logic [CODE_W-1:0]  swap;
      logic [TABLE_W-1:0] table_bits;
      int span;
      int j;
      span = any_code ? 8 : 6;
      for (int k = 0; k < 8; k++)
         pool[k] = CODE_W'(any_code ? k : k + 1);
      for (int k = span - 1; k > 0; k--) begin
         j       = $urandom_range(0, k);
         swap    = pool[k];
         pool[k] = pool[j];
         pool[j] = swap;
      end
      for (int k = 0; k < TABLE_DEPTH; k++)
         table_bits[CODE_W*k +: CODE_W] = pool[k];
      return table_bits;
   endfunction

   // Mostly valid steps along the table, with tick bursts and some noise codes.
   function automatic void pick_item(output logic cmd, output logic [CODE_W-1:0] code,
                                     output logic [TIMER_W-1:0] timer);
      int roll;
      roll  = $urandom_range(0, 99);
      cmd   = CMD_SAMPLE;
      code  = CODE_W'($urandom_range(0, 7));
      timer = TIMER_W'($urandom);
      if (tick_run == 0 && roll == 0)
         tick_run = $urandom_range(18, 26);
      if (tick_run != 0) begin
         tick_run--;
         cmd = CMD_TICK;
      end else if (roll < 14) begin
         cmd = CMD_TICK;
      end else if (roll < 26) begin
         // A noise code; the walk resumes from it when it is in the table.
         for (int k = TABLE_DEPTH - 1; k >= 0; k--)
            if (table_now[CODE_W*k +: CODE_W] == code)
               walk_at = k;
      end else begin
         if ($urandom_range(0, 99) < 20)
            walk_dir = -walk_dir;
         walk_at = (walk_at + TABLE_DEPTH + walk_dir) % TABLE_DEPTH;
         code    = table_now[CODE_W*walk_at +: CODE_W];
      end
   endfunction

   // Load one register setting and run random beats under the given idle rates.
   task automatic run_phase(input logic [TABLE_W-1:0] tbl, input logic drive, input logic fwd,
                            input logic inv, input logic [POS_W-1:0] target, input int count,
                            input int gap_pct, input int stall_pct, input int hold);
      logic               cmd;
      logic [CODE_W-1:0]  code;
      logic [TIMER_W-1:0] timer;
      write_reg(CSR_HALL_TABLE, CSR_DATA_W'(tbl));
      write_reg(CSR_DRIVE_ENABLE, CSR_DATA_W'(drive));
      write_reg(CSR_FORWARD_ORDER, CSR_DATA_W'(fwd));
      write_reg(CSR_COUNT_INVERT, CSR_DATA_W'(inv));
      write_reg(CSR_TARGET, target);
      rsp_stall_pct = stall_pct;
      walk_at  = 0;
      walk_dir = 1;
      for (int k = 0; k < count; k++) begin
         // A long receiver hold-off while the sender keeps offering back to back.
         if (hold != 0 && k == 0) begin
            req_gap_pct   = 0;
            hold_off_left = hold;
         end else if (k == 0 || (hold != 0 && k == 16)) begin
            req_gap_pct = gap_pct;
         end
         pick_item(cmd, code, timer);
         send_beat(cmd, code, timer);
      end
      drain();
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_command     <= CMD_SAMPLE;
      req_hall_code   <= '0;
      req_timer_value <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_HALL_TABLE;
      csr_data        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: first sample only records, then steps, capture, target and faults.
      send_beat(CMD_SAMPLE, 3'd3, 16'hFFFF);
      send_beat(CMD_SAMPLE, 3'd2, 16'h0000);
      send_beat(CMD_SAMPLE, 3'd6, 16'hFFFF);
      send_beat(CMD_TICK,   3'd7, 16'h0000);
      send_beat(CMD_SAMPLE, 3'd2, 16'h1234);
      send_beat(CMD_SAMPLE, 3'd3, 16'hABCD);
      send_beat(CMD_SAMPLE, 3'd3, 16'h0001);
      send_beat(CMD_SAMPLE, 3'd4, 16'h8000);
      send_beat(CMD_SAMPLE, 3'd0, 16'h7FFF);
      send_beat(CMD_SAMPLE, 3'd5, 16'h00FF);
      send_beat(CMD_SAMPLE, 3'd7, 16'hFF00);
      send_beat(CMD_SAMPLE, 3'd1, 16'h5555);
      send_beat(CMD_SAMPLE, 3'd5, 16'hAAAA);
      drain();

      // Pair selection for every code in forward order, then for some in shifted order.
      write_reg(CSR_DRIVE_ENABLE, 32'd1);
      send_beat(CMD_SAMPLE, 3'd4, 16'h0000);
      send_beat(CMD_SAMPLE, 3'd6, 16'hFFFF);
      send_beat(CMD_SAMPLE, 3'd2, 16'h0F0F);
      send_beat(CMD_SAMPLE, 3'd3, 16'hF0F0);
      send_beat(CMD_SAMPLE, 3'd1, 16'h3C3C);
      send_beat(CMD_SAMPLE, 3'd5, 16'hC3C3);
      send_beat(CMD_SAMPLE, 3'd0, 16'h0000);
      send_beat(CMD_SAMPLE, 3'd7, 16'hFFFF);
      drain();
      write_reg(CSR_FORWARD_ORDER, 32'd0);
      write_reg(CSR_COUNT_INVERT, 32'd1);
      send_beat(CMD_SAMPLE, 3'd1, 16'h0000);
      send_beat(CMD_SAMPLE, 3'd3, 16'hFFFF);
      send_beat(CMD_SAMPLE, 3'd2, 16'h1111);
      send_beat(CMD_TICK,   3'd0, 16'hFFFF);
      drain();

      // Random phases: receiver-heavy idling, then sender-heavy, then none.
      run_phase(TABLE_RESET, 1'b1, 1'b1, 1'b0, 32'd3, 260, 37, 50, 40);
      run_phase(shuffled_table(1'b0), 1'b1, 1'b0, 1'b1, -32'sd2, 260, 37, 50, 0);
      run_phase(TABLE_W'($urandom), 1'b1, 1'b1, 1'b0, 32'h7FFF_FFFF, 260, 50, 37, 0);
      run_phase('0, 1'b0, 1'b0, 1'b1, 32'h8000_0000, 260, 50, 37, 0);
      run_phase('1, 1'b1, 1'b0, 1'b0, -32'sd1, 260, 0, 0, 0);
      run_phase(shuffled_table(1'b1), 1'b1, 1'b1, 1'b1, 32'd1, 260, 0, 0, 0);

      repeat (10) @(posedge clock);
      if (ledger.mismatch_count == 0 && ledger.waiting() == 0)
         $display("hall_commutation_position_counter verification clean");
      else
         $display("hall_commutation_position_counter verification failed");
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #20ms;
      $display("hall_commutation_position_counter verification failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/hcpc_pkg.sv
rtl/core/hcpc_decode.sv
rtl/core/hall_commutation_position_counter.sv
tb/hall_commutation_position_counter_test.sv
